// ===== design/mcwd_pkg.sv =====
// shared types and constants of the multi-channel watchdog supervisor
package mcwd_pkg;

	localparam int NUM_CHANNELS   = 3;
	localparam int HEALTH_CHANNEL = 2;
	localparam int MS_PER_S       = 1000;

	localparam int KIND_W     = 2;
	localparam int CHAN_W     = 2;
	localparam int TMO_W      = 16;
	localparam int NOW_W      = 40;
	localparam int DEADLINE_W = 42;
	localparam int PROD_W     = 26;
	localparam int MASK_W     = 3;
	localparam int CNT_W      = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_ARM     = 2'd0,
		KIND_DISARM  = 2'd1,
		KIND_STALL   = 2'd2,
		KIND_CHECK   = 2'd3
	} kind_t;

	// one input item, with its accept flag, as seen by every channel
	typedef struct packed {
		logic             accept;
		kind_t            kind;
		logic [TMO_W-1:0] tmo_sec;
		logic [NOW_W-1:0] now_ms;
	} cmd_t;

	// per-channel state after the item, plus check outcome
	typedef struct packed {
		logic armed;
		logic reported;
		logic flagged;
		logic newly;
	} chan_status_t;

endpackage

// ===== design/mcwd_chan.sv =====
// one watchdog channel: deadline, armed and reported marks, overdue check
module mcwd_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mcwd_pkg::cmd_t        cmd,
	input  logic                  sel,
	input  logic                  force_flag,
	output mcwd_pkg::chan_status_t status
);
	import mcwd_pkg::*;

	logic signed [DEADLINE_W-1:0] deadline_q;
	logic                         armed_q;
	logic                         reported_q;

	logic [PROD_W-1:0]            tmo_ms;
	logic signed [DEADLINE_W-1:0] now_ext;
	logic signed [DEADLINE_W-1:0] deadline_d;
	logic                         armed_d;
	logic                         reported_d;
	logic                         overdue;
	logic                         flag;

	assign tmo_ms  = PROD_W'(cmd.tmo_sec) * PROD_W'(MS_PER_S);
	assign now_ext = $signed({{(DEADLINE_W-NOW_W){1'b0}}, cmd.now_ms});
	assign overdue = armed_q && (now_ext > deadline_q);
	assign flag    = overdue || force_flag;

	always_comb begin
		deadline_d = deadline_q;
		armed_d    = armed_q;
		reported_d = reported_q;
		if (cmd.accept) begin
			case (cmd.kind)
				KIND_CHECK: begin
					if (flag)
						reported_d = 1'b1;
				end
				KIND_ARM: begin
					if (sel) begin
						armed_d    = 1'b1;
						reported_d = 1'b0;
						deadline_d = now_ext + $signed({{(DEADLINE_W-PROD_W){1'b0}}, tmo_ms});
					end
				end
				KIND_DISARM: begin
					if (sel) begin
						armed_d    = 1'b0;
						reported_d = 1'b0;
					end
				end
				KIND_STALL: begin
					if (sel) begin
						armed_d    = 1'b1;
						deadline_d = now_ext - DEADLINE_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= '0;
			armed_q    <= 1'b0;
			reported_q <= 1'b0;
		end else begin
			deadline_q <= deadline_d;
			armed_q    <= armed_d;
			reported_q <= reported_d;
		end
	end

	always_comb begin
		status.armed    = armed_d;
		status.reported = reported_d;
		status.flagged  = (cmd.kind == KIND_CHECK) && flag;
		status.newly    = (cmd.kind == KIND_CHECK) && flag && !reported_q;
	end

endmodule

// ===== design/multi_channel_watchdog_supervisor_top.sv =====
// top level of the multi-channel watchdog supervisor
//
// channel  dir  tdata fields (lsb first)                          tuser
// s_*      in   channel, tmo_sec, now_ms, health_ok (64 bits)      kind
// m_*      out  feed, starved, newly_reported, reported_mask,      -
//               armed_mask, feed_count, starved_count (80 bits)
//
// one transaction per cycle while s_tready is high; each accepted item is captured in the output register
// channel state is updated at the input edge so the next item sees it at once
// the output register holds a result while m_tready is low; s_tready follows it
// reset clears all deadlines, marks, counters and the output valid
module multi_channel_watchdog_supervisor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // channel[1:0], tmo_sec[17:2], now_ms[57:18], health_ok[58]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // feed[0], starved[1], newly_reported[4:2],
	                              // reported_mask[7:5], armed_mask[10:8],
	                              // feed_count[42:11], starved_count[74:43]
);
	import mcwd_pkg::*;

	logic                 accept;
	cmd_t                 cmd;
	logic [CHAN_W-1:0]    channel;
	logic                 health_ok;
	logic                 is_check;
	chan_status_t         status [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] flagged;
	logic [MASK_W-1:0]    newly_mask;
	logic [MASK_W-1:0]    rep_mask;
	logic [MASK_W-1:0]    arm_mask;
	logic                 any_flag;

	logic [CNT_W-1:0]     feed_cnt_q;
	logic [CNT_W-1:0]     starve_cnt_q;
	logic [CNT_W-1:0]     feed_cnt_d;
	logic [CNT_W-1:0]     starve_cnt_d;
	logic                 out_valid_q;
	logic [79:0]          out_data_q;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign channel   = s_tdata[1:0];
	assign health_ok = s_tdata[58];

	always_comb begin
		cmd.accept  = accept;
		cmd.kind    = kind_t'(s_tuser);
		cmd.tmo_sec = s_tdata[17:2];
		cmd.now_ms  = s_tdata[57:18];
	end

	assign is_check = (cmd.kind == KIND_CHECK);

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		mcwd_chan u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.sel        (4'(channel) == 4'(i)),
			.force_flag ((i == HEALTH_CHANNEL) && !health_ok),
			.status     (status[i])
		);
		assign flagged[i] = status[i].flagged;
	end

	// mask bits above the channel count are tied to zero; channels above the mask width are cut off
	for (genvar b = 0; b < MASK_W; b++) begin : g_mask
		if (b < NUM_CHANNELS) begin : g_live
			assign newly_mask[b] = status[b].newly;
			assign rep_mask[b]   = status[b].reported;
			assign arm_mask[b]   = status[b].armed;
		end else begin : g_none
			assign newly_mask[b] = 1'b0;
			assign rep_mask[b]   = 1'b0;
			assign arm_mask[b]   = 1'b0;
		end
	end

	assign any_flag = |flagged;

	always_comb begin
		feed_cnt_d   = feed_cnt_q;
		starve_cnt_d = starve_cnt_q;
		if (accept && is_check) begin
			if (any_flag)
				starve_cnt_d = starve_cnt_q + CNT_W'(1);
			else
				feed_cnt_d = feed_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_cnt_q   <= '0;
			starve_cnt_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			feed_cnt_q   <= feed_cnt_d;
			starve_cnt_q <= starve_cnt_d;
			if (accept)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'b0, starve_cnt_d, feed_cnt_d, arm_mask, rep_mask,
				(is_check ? newly_mask : MASK_W'(0)),
				(is_check && any_flag), (is_check && !any_flag)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	// a check always yields exactly one of feed and starved
	a_check_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_check |=> m_tvalid && (m_tdata[0] ^ m_tdata[1]))
		else $error("check result without single feed/starved");

	// a channel first reported must now carry its reported mark
	a_newly_subset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[4:2] & ~m_tdata[7:5]) == '0))
		else $error("newly reported channel without reported mark");

	// a feeding check reports nothing new
	a_feed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[4:2] == '0))
		else $error("feed with newly reported channel");

	// only checks move the counters
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && is_check) |=> $stable(feed_cnt_q) && $stable(starve_cnt_q))
		else $error("counter moved without a check");
`endif

endmodule
